// ----- design/lft_pkg.sv -----
// Shared constants, field widths, operation codes and record types of the LRU frame table.
// Used by the frame cell and by the top level.
`default_nettype none
package lft_pkg;
   localparam int FRAMES    = 256;
   localparam int PAGES     = 32;
   localparam int PROCESSES = 256;

   localparam int IDX_W  = $clog2(FRAMES);
   localparam int PAGE_W = $clog2(PAGES);
   localparam int PID_W  = $clog2(PROCESSES);
   localparam int FUNC_W = 2;
   localparam int SEC_W  = 32;
   localparam int NS_W   = 30;
   localparam int TS_W   = SEC_W + NS_W;

   localparam int REQ_BITS    = FUNC_W + PAGE_W + PID_W + SEC_W + NS_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = 2 + IDX_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [FUNC_W-1:0] FUNC_TOUCH  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DIRTY  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RMPAGE = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_RMPROC = 2'd3;

   typedef struct packed {
      logic              valid;
      logic              hit;
      logic [IDX_W-1:0]  hit_idx;
      logic              free;
      logic [IDX_W-1:0]  free_idx;
      logic              proc;
      logic [IDX_W-1:0]  proc_idx;
      logic [TS_W-1:0]   old_ts;
      logic [IDX_W-1:0]  old_idx;
   } carry_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [PID_W-1:0]  pid;
      logic [PAGE_W-1:0] page;
      logic [TS_W-1:0]   now;
   } cmd_type;

   typedef struct packed {
      logic             en;
      logic             hit;
      logic [IDX_W-1:0] sel;
   } commit_type;
endpackage
`default_nettype wire

// ----- design/lft_cell.sv -----
// One frame of the table: holds the frame state, folds it into the passing scan record
// and applies the commit of an operation. Depends on lft_pkg.
`default_nettype none
module lft_cell (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [lft_pkg::IDX_W-1:0] cell_index,
   input  wire lft_pkg::cmd_type         cmd,
   input  wire lft_pkg::commit_type      commit,
   input  wire lft_pkg::carry_type       carry_in,
   output lft_pkg::carry_type            carry_out
);
   import lft_pkg::*;

   logic              valid_ff, valid_in;
   logic [PID_W-1:0]  owner_ff, owner_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic              dirty_ff, dirty_in;
   logic [TS_W-1:0]   ts_ff, ts_in;
   carry_type         carry_ff, carry_in_next;
   logic              own_match, page_match, selected;

   assign own_match  = valid_ff && (owner_ff == cmd.pid);
   assign page_match = own_match && (page_ff == cmd.page);
   assign selected   = commit.en && (commit.sel == cell_index);

   always_comb begin
      carry_in_next = carry_in;
      if (!carry_in.hit && page_match) begin
         carry_in_next.hit     = 1'b1;
         carry_in_next.hit_idx = cell_index;
      end
      if (!carry_in.free && !valid_ff) begin
         carry_in_next.free     = 1'b1;
         carry_in_next.free_idx = cell_index;
      end
      if (!carry_in.proc && own_match) begin
         carry_in_next.proc     = 1'b1;
         carry_in_next.proc_idx = cell_index;
      end
      if (ts_ff < carry_in.old_ts) begin
         carry_in_next.old_ts  = ts_ff;
         carry_in_next.old_idx = cell_index;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      owner_in = owner_ff;
      page_in  = page_ff;
      dirty_in = dirty_ff;
      ts_in    = ts_ff;
      if (commit.en) begin
         unique case (cmd.func)
            FUNC_TOUCH: begin
               if (selected) begin
                  ts_in = cmd.now;
                  if (!commit.hit) begin
                     valid_in = 1'b1;
                     owner_in = cmd.pid;
                     page_in  = cmd.page;
                     dirty_in = 1'b0;
                  end
               end
            end
            FUNC_DIRTY: begin
               if (selected && commit.hit) begin
                  dirty_in = 1'b1;
               end
            end
            FUNC_RMPAGE: begin
               if (selected && commit.hit) begin
                  valid_in = 1'b0;
               end
            end
            FUNC_RMPROC: begin
               if (own_match) begin
                  valid_in = 1'b0;
               end
            end
            default: begin
               valid_in = valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      owner_ff <= owner_in;
      page_ff  <= page_in;
      dirty_ff <= dirty_in;
      ts_ff    <= ts_in;
      if (reset) begin
         valid_ff <= 1'b0;
         carry_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         carry_ff <= carry_in_next;
      end
   end

   assign carry_out = carry_ff;
endmodule
`default_nettype wire

// ----- design/lru_frame_table.sv -----
// Top level of the LRU frame table: request and response channels, operation sequencing
// and the row of frame cells. Depends on lft_pkg and lft_cell.
//
// Channel | Direction | Beat contents
// req     | in        | func, page_number, process_id, time_seconds, time_nanoseconds
// rsp     | out       | page_fault, hit, frame_index
//
// The response beat follows its request beat in steps: the scan record walks the row of
// FRAMES cells one frame per cycle, the final record is captured, and then the commit
// updates the table and loads the response register.
// One operation is in flight at a time; req_tready is high while the block is idle, so a
// new request beat is not accepted until the previous operation has committed.
// A stalled response holds the commit until rsp_tready, so no result is lost.
// Reset is synchronous and marks every frame invalid in the same cycle.
`default_nettype none
module lru_frame_table (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // func, page_number, process_id, time_seconds, time_nanoseconds, zero fill
   input  wire logic [lft_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // page_fault, hit, frame_index, zero fill
   output logic [lft_pkg::RSP_TDATA_W-1:0]      rsp_tdata
);
   import lft_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam int P_FUNC = 0;
   localparam int P_PAGE = P_FUNC + FUNC_W;
   localparam int P_PID  = P_PAGE + PAGE_W;
   localparam int P_SEC  = P_PID + PID_W;
   localparam int P_NS   = P_SEC + SEC_W;

   logic [1:0]       state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic             start_ff, start_in;
   carry_type        final_ff, final_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0] rsp_data_ff, rsp_data_in;
   carry_type        chain [FRAMES+1];
   commit_type       commit;
   logic             accept, fire, fault, hit;
   logic [IDX_W-1:0] sel;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign fire       = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      chain[0]          = '0;
      chain[0].valid    = start_ff;
      chain[0].old_ts   = '1;
   end

   genvar g;
   generate
      for (g = 0; g < FRAMES; g++) begin : g_cell
         lft_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_index (IDX_W'(g)),
            .cmd        (cmd_ff),
            .commit     (commit),
            .carry_in   (chain[g]),
            .carry_out  (chain[g+1])
         );
      end
   endgenerate

   always_comb begin
      fault = 1'b0;
      hit   = final_ff.hit;
      sel   = '0;
      unique case (cmd_ff.func)
         FUNC_TOUCH: begin
            if (final_ff.hit) begin
               sel = final_ff.hit_idx;
            end else if (final_ff.free) begin
               sel = final_ff.free_idx;
            end else begin
               sel   = final_ff.old_idx;
               fault = 1'b1;
            end
         end
         FUNC_DIRTY, FUNC_RMPAGE: begin
            if (final_ff.hit) begin
               sel = final_ff.hit_idx;
            end
         end
         FUNC_RMPROC: begin
            hit = final_ff.proc;
            if (final_ff.proc) begin
               sel = final_ff.proc_idx;
            end
         end
         default: begin
            sel = '0;
         end
      endcase
      commit.en  = fire;
      commit.hit = hit;
      commit.sel = sel;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      start_in     = 1'b0;
      final_in     = final_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in.func = req_tdata[P_FUNC +: FUNC_W];
               cmd_in.page = req_tdata[P_PAGE +: PAGE_W];
               cmd_in.pid  = req_tdata[P_PID +: PID_W];
               cmd_in.now  = {req_tdata[P_SEC +: SEC_W], req_tdata[P_NS +: NS_W]};
               start_in    = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (chain[FRAMES].valid) begin
               final_in = chain[FRAMES];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (fire) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {sel, hit, fault};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      final_ff    <= final_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_data_ff);
endmodule
`default_nettype wire

// ----- sim/tb_lru_frame_table.sv -----
// Testbench for the LRU frame table: drives random and directed operations on the request
// stream and checks every response against a behavioral frame table. Depends on lft_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tb_lru_frame_table;
   import lft_pkg::*;

   typedef struct packed {
      logic             fault;
      logic             hit;
      logic [IDX_W-1:0] idx;
   } rsp_type;

   class frame_table_sb;
      logic              valid [FRAMES];
      logic [PID_W-1:0]  owner [FRAMES];
      logic [PAGE_W-1:0] page  [FRAMES];
      logic              dirty [FRAMES];
      logic [TS_W-1:0]   stamp [FRAMES];
      rsp_type           pending [$];
      int                errors;
      int                checked;

      function void clear_all();
         for (int f = 0; f < FRAMES; f++) begin
            valid[f] = 0; owner[f] = '0; page[f] = '0; dirty[f] = 0; stamp[f] = '0;
         end
         pending.delete();
         errors = 0;
         checked = 0;
      endfunction

      function void clear_frame(int f);
         valid[f] = 0; owner[f] = '0; page[f] = '0; dirty[f] = 0; stamp[f] = '0;
      endfunction

      function void note_request(logic [FUNC_W-1:0] fn, logic [PAGE_W-1:0] pg,
                                 logic [PID_W-1:0] pid, logic [TS_W-1:0] now);
         rsp_type r;
         int      f;
         int      best;
         r = '0;
         f = -1;
         if (fn != FUNC_RMPROC) begin
            for (int i = 0; i < FRAMES; i++)
               if (f < 0 && valid[i] && owner[i] == pid && page[i] == pg) f = i;
         end
         case (fn)
            FUNC_TOUCH: begin
               if (f >= 0) begin
                  r.hit = 1;
                  stamp[f] = now;
               end else begin
                  for (int i = 0; i < FRAMES; i++)
                     if (f < 0 && !valid[i]) f = i;
                  if (f < 0) begin
                     r.fault = 1;
                     best = 0;
                     for (int i = 1; i < FRAMES; i++)
                        if (stamp[i] < stamp[best]) best = i;
                     f = best;
                  end
                  valid[f] = 1; owner[f] = pid; page[f] = pg; dirty[f] = 0; stamp[f] = now;
               end
               r.idx = f[IDX_W-1:0];
            end
            FUNC_DIRTY: begin
               if (f >= 0) begin
                  r.hit = 1; r.idx = f[IDX_W-1:0]; dirty[f] = 1;
               end
            end
            FUNC_RMPAGE: begin
               if (f >= 0) begin
                  r.hit = 1; r.idx = f[IDX_W-1:0]; clear_frame(f);
               end
            end
            default: begin
               for (int i = 0; i < FRAMES; i++)
                  if (valid[i] && owner[i] == pid) begin
                     if (!r.hit) begin
                        r.hit = 1; r.idx = i[IDX_W-1:0];
                     end
                     clear_frame(i);
                  end
            end
         endcase
         pending.push_back(r);
      endfunction

      function void check_response(logic [RSP_TDATA_W-1:0] data);
         rsp_type got;
         rsp_type exp;
         got.fault = data[0];
         got.hit   = data[1];
         got.idx   = data[2 +: IDX_W];
         if (pending.size() == 0) begin
            $display("%0t: unexpected response, actual %p", $time, got);
            errors++;
            return;
         end
         exp = pending.pop_front();
         checked++;
         if (got.fault !== exp.fault) begin
            $display("%0t: page_fault expected %0b actual %0b", $time, exp.fault, got.fault);
            errors++;
         end
         if (got.hit !== exp.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, exp.hit, got.hit);
            errors++;
         end
         if (got.idx !== exp.idx) begin
            $display("%0t: frame_index expected %0d actual %0d", $time, exp.idx, got.idx);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   req_tvalid = 0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   frame_table_sb table_model = new();
   bit  quiet_phase = 0;
   int  idle_cycles = 0;
   int  touches = 0;
   int  faults_seen = 0;

   always #5 clock = ~clock;

   lru_frame_table dut (.*);

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            table_model.check_response(rsp_tdata);
            if (rsp_tdata[0] === 1'b1) faults_seen++;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 4000) begin
            $display("%0t: watchdog expired", $time);
            $display("[lru_frame_table] ERROR");
            $finish;
         end
      end
   end

   // Response side stalls in random bursts until the quiet phase.
   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 15);
            rsp_tready <= 0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1;
            @(posedge clock);
         end
      end
   end

   // The beat stays valid after acceptance until the next beat, an idle burst or a drain
   // replaces it; the block is busy for the whole operation, so it is not taken twice.
   task automatic send_beat(input logic [FUNC_W-1:0] fn, input logic [PAGE_W-1:0] pg,
                            input logic [PID_W-1:0] pid, input logic [SEC_W-1:0] sec,
                            input logic [NS_W-1:0] ns);
      int n;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 15);
         req_tvalid <= 0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= REQ_TDATA_W'({ns, sec, pid, pg, fn});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      table_model.note_request(fn, pg, pid, {sec, ns});
      if (fn == FUNC_TOUCH) touches++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (table_model.pending.size() != 0) @(posedge clock);
   endtask

   task automatic send_random(input int mode, input int t);
      logic [FUNC_W-1:0] fn;
      logic [PID_W-1:0]  pid;
      int                r;
      r = $urandom_range(0, 9);
      fn = (r < 6) ? FUNC_TOUCH : (r < 8) ? FUNC_DIRTY : (r < 9) ? FUNC_RMPAGE : FUNC_RMPROC;
      pid = (mode == 0) ? $urandom_range(0, 7) : $urandom;
      if (mode == 2)
         send_beat(fn, $urandom, pid, $urandom, $urandom);
      else
         send_beat(fn, $urandom_range(0, 31), pid, t, $urandom_range(0, 999999999));
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      table_model.clear_all();

      // Directed: misses on an empty table, hits, dirty, removals and extreme fields.
      send_beat(FUNC_DIRTY, 5'd3, 8'd1, 0, 0);
      send_beat(FUNC_RMPAGE, 5'd3, 8'd1, 0, 0);
      send_beat(FUNC_RMPROC, 5'd0, 8'd1, 0, 0);
      send_beat(FUNC_TOUCH, 5'd0, 8'd0, 32'd0, 30'd0);
      send_beat(FUNC_TOUCH, 5'd31, 8'd255, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
      send_beat(FUNC_TOUCH, 5'd31, 8'd255, 32'd7, 30'd999_999_999);
      send_beat(FUNC_TOUCH, 5'd3, 8'd1, 32'd8, 30'h3FFF_FFFF);
      send_beat(FUNC_TOUCH, 5'd4, 8'd1, 32'd9, 30'd1);
      send_beat(FUNC_DIRTY, 5'd3, 8'd1, 0, 0);
      send_beat(FUNC_DIRTY, 5'd3, 8'd2, 0, 0);
      send_beat(FUNC_TOUCH, 5'd3, 8'd1, 32'd10, 30'd0);
      send_beat(FUNC_RMPAGE, 5'd31, 8'd255, 0, 0);
      send_beat(FUNC_TOUCH, 5'd9, 8'd9, 32'd11, 30'd0);
      send_beat(FUNC_RMPROC, 5'd0, 8'd1, 0, 0);
      send_beat(FUNC_RMPROC, 5'd0, 8'd1, 0, 0);
      drain();

      // Fill the table, then force replacements with equal and distinct stamps.
      for (int i = 0; i < FRAMES + 40; i++)
         send_beat(FUNC_TOUCH, i[PAGE_W-1:0], i[12:5] ^ 8'h5A, (i < 20) ? 32'd50 : i,
                   $urandom_range(0, 3));
      drain();
      for (int i = 0; i < 60; i++) send_random(0, 1000 + i);
      for (int i = 0; i < 60; i++) send_random(1, $urandom);
      for (int i = 0; i < 20; i++) send_random(2, 0);
      drain();
      quiet_phase = 1;
      for (int i = 0; i < 50; i++) send_random(0, 5000 + i);
      drain();
      repeat (2 * FRAMES + 20) @(posedge clock);

      $display("Checked %0d responses: %0d touches, %0d page faults, all four operations.",
               table_model.checked, touches, faults_seen);
      if (table_model.errors == 0 && table_model.pending.size() == 0)
         $display("[lru_frame_table] OK");
      else
         $display("[lru_frame_table] ERROR");
      $finish;
   end
endmodule
`default_nettype wire

// ----- lru_frame_table.f -----
design/lft_pkg.sv
design/lft_cell.sv
design/lru_frame_table.sv
sim/tb_lru_frame_table.sv
